>>> rtl/smfd_pkg.sv
// Shared types, register codes and reset constants for the stereo multitap delay.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none

package smfd_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // Configuration port
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 64;
  localparam int PAIR_REGS      = 4;

  localparam logic [CFG_INDEX_BITS-1:0] REG_DRY        = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PAIR_FIRST = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_PAIR_LAST  = 3'd4;

  localparam logic [CFG_DATA_BITS-1:0] PAIR0_RESET = 64'h00530FFF26530FFF;
  localparam logic [CFG_DATA_BITS-1:0] PAIR_RESET  = 64'h00530FFF00530FFF;

  // Tap length is the 16-bit field plus one, so it needs one more bit
  localparam int LEN_BITS = 17;

  localparam logic [7:0]        CODE_MAX  = 8'd128;
  localparam logic signed [8:0] FB_UNITY  = 9'sd64;

  typedef logic signed [8:0] coef_t;

  // Per-cycle control from the sequencer to both lanes
  typedef struct packed {
    logic  issue;     // read the tap's delay entry this cycle
    logic  clear;     // write zero at the given address
    logic  dry;       // add the tap input to the tap output
    coef_t fb_coef;   // feedback code minus 64
    coef_t wet_coef;  // wet code
  } lane_ctrl_t;

  function automatic logic [7:0] clamp_code(input logic [7:0] code);
    return (code > CODE_MAX) ? CODE_MAX : code;
  endfunction

endpackage

`default_nettype wire

>>> rtl/smfd_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`default_nettype none

module smfd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16,
  localparam int ADDR_BITS = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/smfd_lane.sv
// One channel lane: delay store, coefficient multiply stage and tap arithmetic.
// Depends on smfd_pkg and smfd_ram.
`default_nettype none

module smfd_lane #(
  parameter int SAMPLE_BITS = 24,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  smfd_pkg::lane_ctrl_t          ctrl,
  input  logic [AW-1:0]                 addr,
  input  logic                          load,
  input  logic signed [SAMPLE_BITS-1:0] sample_in,
  output logic signed [SAMPLE_BITS-1:0] sample
);

  // sample times a 9-bit code, plus the shifted sample, fits here
  localparam int SW = SAMPLE_BITS + 9;
  localparam logic signed [SW-1:0] FB_HALF  = SW'(32);
  localparam logic signed [SW-1:0] WET_HALF = SW'(64);
  localparam logic signed [SW-1:0] ZERO     = '0;

  function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [SW-1:0] v);
    logic [SW-SAMPLE_BITS:0] upper;
    upper = v[SW-1:SAMPLE_BITS-1];
    if (upper == '0 || upper == '1) begin
      return v[SAMPLE_BITS-1:0];
    end
    return {v[SW-1], {(SAMPLE_BITS-1){~v[SW-1]}}};
  endfunction

  logic                          we;
  logic [AW-1:0]                 waddr;
  logic [SAMPLE_BITS-1:0]        wdata;
  logic [SAMPLE_BITS-1:0]        rdata;
  logic signed [SAMPLE_BITS-1:0] stored;

  // stage 1: read data arrives, coefficients ride along
  logic                  s1_valid;
  logic [AW-1:0]         s1_addr;
  logic                  s1_dry;
  smfd_pkg::coef_t       s1_fb;
  smfd_pkg::coef_t       s1_wet;

  // stage 2: products registered
  logic                  s2_valid;
  logic [AW-1:0]         s2_addr;
  logic                  s2_dry;
  logic signed [SW-1:0]  s2_pfb;
  logic signed [SW-1:0]  s2_pwet;

  logic signed [SW-1:0]  store_sum;
  logic signed [SW-1:0]  out_sum;
  logic signed [SW-1:0]  store_q;
  logic signed [SW-1:0]  out_q;
  logic signed [SW-1:0]  dry_term;

  smfd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (ctrl.issue),
    .raddr (addr),
    .rdata (rdata)
  );

  assign stored = rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= ctrl.issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr <= addr;
    s1_dry  <= ctrl.dry;
    s1_fb   <= ctrl.fb_coef;
    s1_wet  <= ctrl.wet_coef;
    s2_addr <= s1_addr;
    s2_dry  <= s1_dry;
    s2_pfb  <= SW'(stored) * SW'(s1_fb);
    s2_pwet <= SW'(stored) * SW'(s1_wet);
  end

  // floor shifts round to nearest with the half added first
  assign dry_term  = s2_dry ? (SW'(sample) <<< 7) : ZERO;
  assign store_sum = s2_pfb + (SW'(sample) <<< 6) + FB_HALF;
  assign out_sum   = s2_pwet + dry_term + WET_HALF;
  assign store_q   = store_sum >>> 6;
  assign out_q     = out_sum >>> 7;

  assign we    = ctrl.clear | s2_valid;
  assign waddr = ctrl.clear ? addr : s2_addr;
  assign wdata = ctrl.clear ? '0 : sat(store_q);

  // running sample: tap input, then tap output feeding the next tap
  always_ff @(posedge clk) begin
    if (load) begin
      sample <= sample_in;
    end else if (s2_valid) begin
      sample <= sat(out_q);
    end
  end

endmodule

`default_nettype wire

>>> rtl/stereo_multitap_feedback_delay_core.sv
// Stereo multitap feedback delay: top level with config registers, tap sequencer,
// two channel lanes and the output register. Depends on smfd_pkg and smfd_lane.
//
// Usage:
//  - Input channel (in_valid/in_ready, left_in/right_in) takes one stereo request.
//  - Output channel (out_valid/out_ready, left_out/right_out) returns one result
//    per request, in order.
//  - Config port (cfg_we/cfg_index/cfg_data) writes register cfg_index;
//    index 0 is the dry flag, 1..4 are the tap pair words, others ignored.
//    Write only while no request is in flight.
//  - Taps run one per cycle through a three-stage pipeline (read, multiply,
//    sum/write back), both channels side by side. An accepted request passes
//    through the run, drain and done states to out_valid; a new request is
//    taken only in the idle or done state, after the last tap of the previous
//    one is written back, as the single delay memory per channel is walked tap by tap.
//  - After reset the delay memories are cleared one entry a cycle, all
//    TAP_COUNT*TAP_DEPTH entries (524288 at the defaults), with in_ready low.
//    Config writes are taken during the clear.
//  - If the receiver stalls, the finished result waits in the output register
//    and the next request holds in the done state until the slot frees.
`default_nettype none

module stereo_multitap_feedback_delay_core #(
  parameter int TAP_DEPTH   = 65536,
  parameter int TAP_COUNT   = 8,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [SAMPLE_BITS-1:0]         left_in,
  input  logic signed [SAMPLE_BITS-1:0]         right_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [SAMPLE_BITS-1:0]         left_out,
  output logic signed [SAMPLE_BITS-1:0]         right_out,
  input  logic                                  cfg_we,
  input  logic [smfd_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [smfd_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int DEPTH = TAP_COUNT * TAP_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(TAP_DEPTH);
  localparam int TW    = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
  localparam int LB    = smfd_pkg::LEN_BITS;

  localparam logic [TW-1:0] TAP_LAST  = TW'(TAP_COUNT - 1);
  localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);
  localparam logic [AW-1:0] TAP_SPAN  = AW'(TAP_DEPTH);
  localparam logic [LB-1:0] LEN_MAX   = LB'(TAP_DEPTH);

  smfd_pkg::state_t state;
  smfd_pkg::state_t state_next;

  // config registers
  logic                                dry;
  logic [smfd_pkg::CFG_DATA_BITS-1:0]  tap_pair [smfd_pkg::PAIR_REGS];

  // sequencer
  logic [TW-1:0]  tap;
  logic [AW-1:0]  clr_addr;
  logic           drain;
  logic [PW-1:0]  pos [TAP_COUNT];
  logic           load;
  logic           load_out;

  // current tap decode
  logic [2:0]     tap3;
  logic [31:0]    word;
  logic [LB-1:0]  len_raw;
  logic [LB-1:0]  len;
  logic [PW-1:0]  pos_cur;
  logic [PW-1:0]  pos_eff;
  logic [LB-1:0]  pos_inc;
  logic [PW-1:0]  pos_wrap;
  logic [AW-1:0]  rd_addr;
  logic [AW-1:0]  lane_addr;

  smfd_pkg::lane_ctrl_t ctrl;

  logic signed [SAMPLE_BITS-1:0] left_x;
  logic signed [SAMPLE_BITS-1:0] right_x;

  // ---------------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      dry <= 1'b1;
      for (int i = 0; i < smfd_pkg::PAIR_REGS; i++) begin
        tap_pair[i] <= (i == 0) ? smfd_pkg::PAIR0_RESET : smfd_pkg::PAIR_RESET;
      end
    end else if (cfg_we) begin
      if (cfg_index == smfd_pkg::REG_DRY) begin
        dry <= cfg_data[0];
      end else if (cfg_index >= smfd_pkg::REG_PAIR_FIRST &&
                   cfg_index <= smfd_pkg::REG_PAIR_LAST) begin
        tap_pair[2'(cfg_index - smfd_pkg::REG_PAIR_FIRST)] <= cfg_data;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tap decode: length, codes, wrapped position and memory address
  // ---------------------------------------------------------------------------
  always_comb begin
    tap3     = 3'(tap);
    word     = tap3[0] ? tap_pair[tap3[2:1]][63:32] : tap_pair[tap3[2:1]][31:0];
    len_raw  = {1'b0, word[15:0]} + LB'(1);
    len      = (len_raw > LEN_MAX) ? LEN_MAX : len_raw;
    pos_cur  = pos[tap];
    // a position left beyond a shortened length restarts at zero
    pos_eff  = (LB'(pos_cur) >= len) ? '0 : pos_cur;
    pos_inc  = LB'(pos_eff) + LB'(1);
    pos_wrap = (pos_inc >= len) ? '0 : pos_inc[PW-1:0];
    rd_addr  = AW'(tap) * TAP_SPAN + AW'(pos_eff);
  end

  assign lane_addr = (state == smfd_pkg::ST_CLEAR) ? clr_addr : rd_addr;

  always_comb begin
    ctrl.issue    = (state == smfd_pkg::ST_RUN);
    ctrl.clear    = (state == smfd_pkg::ST_CLEAR);
    ctrl.dry      = dry;
    ctrl.fb_coef  = $signed({1'b0, smfd_pkg::clamp_code(word[23:16])}) - smfd_pkg::FB_UNITY;
    ctrl.wet_coef = $signed({1'b0, smfd_pkg::clamp_code(word[31:24])});
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= smfd_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      smfd_pkg::ST_CLEAR: begin
        if (clr_addr == ADDR_LAST) begin
          state_next = smfd_pkg::ST_IDLE;
        end
      end
      smfd_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = smfd_pkg::ST_RUN;
        end
      end
      smfd_pkg::ST_RUN: begin
        if (tap == TAP_LAST) begin
          state_next = smfd_pkg::ST_DRAIN;
        end
      end
      smfd_pkg::ST_DRAIN: begin
        if (drain) begin
          state_next = smfd_pkg::ST_DONE;
        end
      end
      smfd_pkg::ST_DONE: begin
        // hand the result over and take the next request in the same cycle
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          in_ready   = 1'b1;
          state_next = in_valid ? smfd_pkg::ST_RUN : smfd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = smfd_pkg::ST_CLEAR;
      end
    endcase
  end

  assign load = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap      <= '0;
      clr_addr <= '0;
      drain    <= 1'b0;
    end else begin
      if (state == smfd_pkg::ST_RUN) begin
        tap <= (tap == TAP_LAST) ? '0 : tap + 1'b1;
      end
      if (state == smfd_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (state == smfd_pkg::ST_DRAIN) begin
        drain <= ~drain;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TAP_COUNT; i++) begin
        pos[i] <= '0;
      end
    end else if (state == smfd_pkg::ST_RUN) begin
      pos[tap] <= pos_wrap;
    end
  end

  // ---------------------------------------------------------------------------
  // Channel lanes
  // ---------------------------------------------------------------------------
  smfd_lane #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DEPTH       (DEPTH)
  ) u_left (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .addr      (lane_addr),
    .load      (load),
    .sample_in (left_in),
    .sample    (left_x)
  );

  smfd_lane #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .DEPTH       (DEPTH)
  ) u_right (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (ctrl),
    .addr      (lane_addr),
    .load      (load),
    .sample_in (right_in),
    .sample    (right_x)
  );

  // ---------------------------------------------------------------------------
  // Output register: merges both lanes into one result
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      left_out  <= left_x;
      right_out <= right_x;
    end
  end

`ifndef SYNTHESIS
  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    state == smfd_pkg::ST_RUN |-> tap <= TAP_LAST)
    else $error("tap counter out of range");

  a_start: assert property (@(posedge clk) disable iff (rst)
    load |=> state == smfd_pkg::ST_RUN && tap == '0)
    else $error("accepted request did not start at tap zero");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    state == smfd_pkg::ST_RUN && tap == TAP_LAST |=>
      state == smfd_pkg::ST_DRAIN ##1 state == smfd_pkg::ST_DRAIN
      ##1 state == smfd_pkg::ST_DONE)
    else $error("pipeline drain length wrong");

  a_hold_done: assert property (@(posedge clk) disable iff (rst)
    state == smfd_pkg::ST_DONE && out_valid && !out_ready |=>
      state == smfd_pkg::ST_DONE)
    else $error("result left done state while output slot was full");
`endif

endmodule

`default_nettype wire

>>> verif/smfd_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the stereo multitap delay: tracks config writes, predicts each
// output pair from accepted requests and compares it. Depends on smfd_pkg.
module smfd_checker #(
  parameter int TAP_DEPTH   = 65536,
  parameter int TAP_COUNT   = 8,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  logic signed [SAMPLE_BITS-1:0]       left_in,
  input  logic signed [SAMPLE_BITS-1:0]       right_in,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  logic signed [SAMPLE_BITS-1:0]       left_out,
  input  logic signed [SAMPLE_BITS-1:0]       right_out,
  input  logic                                cfg_we,
  input  logic [smfd_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [smfd_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output int                                  mismatches,
  output int                                  outstanding,
  output int                                  results_seen
);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef struct packed {
    sample_t left;
    sample_t right;
  } stereo_t;

  localparam longint SAT_HI    = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAT_LO    = -SAT_HI - 1;
  localparam bit     DRY_RESET = 1'b1;
  localparam int     MAX_PRINTS = 100;

  bit                                   dry_on;
  logic [smfd_pkg::CFG_DATA_BITS-1:0]   pair_word [smfd_pkg::PAIR_REGS];
  int                                   tap_pos [TAP_COUNT];
  // 2-state, so zero from time 0; reset is applied once, which matches the clear
  bit signed [SAMPLE_BITS-1:0] left_line [TAP_COUNT*TAP_DEPTH];
  bit signed [SAMPLE_BITS-1:0] right_line [TAP_COUNT*TAP_DEPTH];
  stereo_t                    expected_pairs [$];

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    results_seen = 0;
  end

  function automatic longint saturate_sample(input longint v);
    if (v > SAT_HI) return SAT_HI;
    if (v < SAT_LO) return SAT_LO;
    return v;
  endfunction

  // One tap, one channel: new store word and tap output, both round-half-up
  function automatic void tap_arith(input longint d, input longint x, input longint fb,
                                    input longint wet, output longint stored,
                                    output longint y);
    stored = saturate_sample((d * (fb - smfd_pkg::FB_UNITY) + x * 64 + 32) >>> 6);
    y      = saturate_sample(((dry_on ? x * 128 : longint'(0)) + d * wet + 64) >>> 7);
  endfunction

  function automatic stereo_t run_delay_taps(input stereo_t s);
    stereo_t      res;
    longint       l, r, fb, wet, st, y;
    logic [31:0]  w;
    int           t, len, pos, at;
    l = s.left;
    r = s.right;
    for (t = 0; t < TAP_COUNT; t++) begin
      w   = pair_word[t / 2][32 * (t % 2) +: 32];
      len = int'(w[15:0]) + 1;
      if (len > TAP_DEPTH) len = TAP_DEPTH;
      fb  = (w[23:16] > smfd_pkg::CODE_MAX) ? smfd_pkg::CODE_MAX : w[23:16];
      wet = (w[31:24] > smfd_pkg::CODE_MAX) ? smfd_pkg::CODE_MAX : w[31:24];
      pos = tap_pos[t];
      if (pos >= len) pos = 0;
      at = t * TAP_DEPTH + pos;
      tap_arith(left_line[at], l, fb, wet, st, y);
      left_line[at] = st[SAMPLE_BITS-1:0];
      l = y;
      tap_arith(right_line[at], r, fb, wet, st, y);
      right_line[at] = st[SAMPLE_BITS-1:0];
      r = y;
      pos++;
      if (pos >= len) pos = 0;
      tap_pos[t] = pos;
    end
    res.left  = l[SAMPLE_BITS-1:0];
    res.right = r[SAMPLE_BITS-1:0];
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_PRINTS) $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  always @(posedge clk) begin
    stereo_t want;
    if (rst) begin
      dry_on = DRY_RESET;
      pair_word[0] = smfd_pkg::PAIR0_RESET;
      for (int k = 1; k < smfd_pkg::PAIR_REGS; k++) pair_word[k] = smfd_pkg::PAIR_RESET;
      for (int k = 0; k < TAP_COUNT; k++) tap_pos[k] = 0;
      expected_pairs.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == smfd_pkg::REG_DRY)
          dry_on = cfg_data[0];
        else if (cfg_index >= smfd_pkg::REG_PAIR_FIRST && cfg_index <= smfd_pkg::REG_PAIR_LAST)
          pair_word[cfg_index - smfd_pkg::REG_PAIR_FIRST] = cfg_data;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (expected_pairs.size() == 0) begin
          report_mismatch($sformatf("result with no request pending L=%0d R=%0d",
                                    left_out, right_out));
        end else begin
          want = expected_pairs.pop_front();
          if (left_out !== want.left)
            report_mismatch($sformatf("left_out %0d, expected %0d", left_out, want.left));
          if (right_out !== want.right)
            report_mismatch($sformatf("right_out %0d, expected %0d", right_out, want.right));
        end
      end
      if (in_valid && in_ready)
        expected_pairs.push_back(run_delay_taps({left_in, right_in}));
    end
    outstanding = expected_pairs.size();
  end

endmodule

>>> verif/tb_stereo_multitap_feedback_delay_core.sv
`timescale 1ns / 100ps
// Top testbench for the stereo multitap feedback delay core: clock, reset,
// request and config stimulus, output back-pressure and verdict. Uses smfd_pkg and smfd_checker.
module tb_stereo_multitap_feedback_delay_core;

  localparam int TAP_DEPTH       = 65536;
  localparam int TAP_COUNT       = 8;
  localparam int SAMPLE_BITS     = 24;
  localparam int HALF_PERIOD     = 6;        // 12 ns clock
  localparam int RESET_CYCLES    = 11;
  // Extra wait after the last result, before touching config
  localparam int SETTLE_CYCLES   = TAP_COUNT + 8;
  localparam int RANDOM_PHASES   = 11;
  localparam int ITEMS_PER_PHASE = 107;
  // Limit covers the memory clear after reset and all requests at worst,
  // so this is several times the slow run
  localparam int CYCLE_LIMIT     = 3_000_000;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic [smfd_pkg::CFG_INDEX_BITS-1:0] cfg_index_t;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic                                clk       = 1'b0;
  logic                                rst       = 1'b1;
  logic                                in_valid  = 1'b0;
  logic                                in_ready;
  sample_t                             left_in   = '0;
  sample_t                             right_in  = '0;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  sample_t                             left_out;
  sample_t                             right_out;
  logic                                cfg_we    = 1'b0;
  cfg_index_t                          cfg_index = '0;
  logic [smfd_pkg::CFG_DATA_BITS-1:0]  cfg_data  = '0;

  int mismatches, outstanding, results_seen;
  int cycle_count    = 0;
  int requests_sent  = 0;
  int settings_run   = 0;
  bit src_idle       = 1'b1;
  bit sink_idle      = 1'b1;
  int sink_stall     = 0;

  always #HALF_PERIOD clk = ~clk;

  stereo_multitap_feedback_delay_core #(
    .TAP_DEPTH  (TAP_DEPTH),
    .TAP_COUNT  (TAP_COUNT),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .left_in  (left_in),
    .right_in (right_in),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .left_out (left_out),
    .right_out(right_out),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  smfd_checker #(
    .TAP_DEPTH  (TAP_DEPTH),
    .TAP_COUNT  (TAP_COUNT),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .left_in     (left_in),
    .right_in    (right_in),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .left_out    (left_out),
    .right_out   (right_out),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding),
    .results_seen(results_seen)
  );

  // Watchdog: a hang anywhere (clear that never ends, lost result) lands here
  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d results still pending", cycle_count, outstanding);
    $display("tb_stereo_multitap_feedback_delay_core failed");
    $finish;
  end

  // Receiver back-pressure: random stall bursts while enabled.
  // Changes on the falling edge so the DUT sees a stable ready at the rising edge.
  always @(negedge clk) begin
    if (sink_stall > 0) begin
      out_ready = 1'b0;
      sink_stall--;
    end else if (sink_idle && $urandom_range(0, 7) == 0) begin
      out_ready = 1'b0;
      sink_stall = $urandom_range(1, 11) - 1;
    end else begin
      out_ready = 1'b1;
    end
  end

  // One 32-bit tap half: {wet code, feedback code, length-1}
  function automatic logic [31:0] tap_half(input logic [15:0] len_m1, input logic [7:0] fb,
                                           input logic [7:0] wet);
    return {wet, fb, len_m1};
  endfunction

  // Mostly short taps so stored samples come back within a phase; now and then
  // a long one or the full store. Codes sometimes above 128 to hit the clamp.
  function automatic logic [31:0] rand_half();
    logic [15:0] len_m1;
    logic [7:0]  fb, wet;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick < 7)       len_m1 = 16'($urandom_range(0, 15));
    else if (pick == 7) len_m1 = 16'($urandom_range(16, 255));
    else if (pick == 8) len_m1 = 16'hFFFF;
    else                len_m1 = 16'($urandom);
    fb  = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(129, 255))
                                      : 8'($urandom_range(0, 128));
    wet = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(129, 255))
                                      : 8'($urandom_range(0, 128));
    return tap_half(len_m1, fb, wet);
  endfunction

  function automatic sample_t rand_sample();
    case ($urandom_range(0, 7))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return '0;
      3:       return sample_t'($urandom_range(0, 255)) - sample_t'(128);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic cfg_write(input cfg_index_t idx,
                           input logic [smfd_pkg::CFG_DATA_BITS-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Writes to indexes past the last pair register; the block must ignore them
  task automatic poke_unused_regs();
    for (int i = smfd_pkg::REG_PAIR_LAST + 1; i < (1 << smfd_pkg::CFG_INDEX_BITS); i++)
      cfg_write(cfg_index_t'(i), {$urandom, $urandom});
  endtask

  // Present one request and hold it until accepted. An optional idle burst
  // goes first with valid low; otherwise valid stays high into the next request.
  task automatic push_sample(input sample_t l, input sample_t r);
    int gap;
    gap = (src_idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    left_in  = l;
    right_in = r;
    do @(posedge clk); while (!in_ready);
    requests_sent++;
  endtask

  // Drain: no request in flight, pipeline quiet, safe for config writes
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    wait (outstanding == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_random_setting();
    // full random word on the dry register: only bit 0 counts
    cfg_write(smfd_pkg::REG_DRY, {$urandom, $urandom});
    for (int k = 0; k < smfd_pkg::PAIR_REGS; k++)
      cfg_write(cfg_index_t'(smfd_pkg::REG_PAIR_FIRST + k), {rand_half(), rand_half()});
    if ($urandom_range(0, 3) == 0) poke_unused_regs();
    settings_run++;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings as they come: long taps, stores all zero, so this is
    // pure pass-through of the extremes. The first request waits out the clear.
    settings_run++;
    push_sample('0, '0);
    push_sample(SAMPLE_MAX, SAMPLE_MIN);
    push_sample(SAMPLE_MIN, SAMPLE_MAX);
    push_sample(-sample_t'(1), sample_t'(1));
    push_sample(SAMPLE_MAX, SAMPLE_MAX);

    // Edge settings: single-sample tap, codes clamped at 128, full-length tap,
    // unity feedback, wet at 128, plus writes to unused indexes
    settle();
    cfg_write(smfd_pkg::REG_DRY, 64'd1);
    cfg_write(smfd_pkg::REG_PAIR_FIRST,
              {tap_half(16'd2, 8'd0, 8'd128), tap_half(16'd0, 8'd255, 8'd255)});
    cfg_write(cfg_index_t'(smfd_pkg::REG_PAIR_FIRST + 1),
              {tap_half(16'd1, 8'd64, 8'd200), tap_half(16'hFFFF, 8'd128, 8'd64)});
    cfg_write(cfg_index_t'(smfd_pkg::REG_PAIR_FIRST + 2),
              {tap_half(16'd3, 8'd100, 8'd90), tap_half(16'd0, 8'd130, 8'd1)});
    cfg_write(cfg_index_t'(smfd_pkg::REG_PAIR_FIRST + 3),
              {tap_half(16'd5, 8'd32, 8'd128), tap_half(16'd2, 8'd128, 8'd128)});
    poke_unused_regs();
    settings_run++;
    push_sample(SAMPLE_MAX, SAMPLE_MAX);
    push_sample(SAMPLE_MIN, SAMPLE_MIN);
    push_sample(SAMPLE_MAX, SAMPLE_MIN);
    push_sample('0, -sample_t'(1));
    push_sample(SAMPLE_MAX, SAMPLE_MAX);
    push_sample(SAMPLE_MIN, SAMPLE_MAX);

    // Wet only, every tap 16 long
    settle();
    cfg_write(smfd_pkg::REG_DRY, 64'd0);
    for (int k = 0; k < smfd_pkg::PAIR_REGS; k++)
      cfg_write(cfg_index_t'(smfd_pkg::REG_PAIR_FIRST + k),
                {tap_half(16'd15, 8'($urandom_range(0, 128)), 8'd128),
                 tap_half(16'd15, 8'($urandom_range(0, 128)), 8'd128)});
    settings_run++;
    repeat (8) push_sample(rand_sample(), rand_sample());

    // Shorten every tap to 4: positions left beyond the new length restart at 0
    settle();
    cfg_write(smfd_pkg::REG_DRY, 64'd1);
    for (int k = 0; k < smfd_pkg::PAIR_REGS; k++)
      cfg_write(cfg_index_t'(smfd_pkg::REG_PAIR_FIRST + k),
                {tap_half(16'd3, 8'd96, 8'd64), tap_half(16'd3, 8'd0, 8'd0)});
    settings_run++;
    repeat (6) push_sample(rand_sample(), rand_sample());

    // Random settings, each held for one phase; idling on either side is
    // switched per phase so some phases run back to back, the last one always
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      settle();
      write_random_setting();
      src_idle  = (ph != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      sink_idle = (ph != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      repeat (ITEMS_PER_PHASE) push_sample(rand_sample(), rand_sample());
    end

    settle();
    $display("covered %0d stereo requests under %0d tap settings, %0d results compared",
             requests_sent, settings_run, results_seen);
    $display("settings included clamped codes, full-length and single-sample taps, dry on/off");
    if (mismatches == 0) begin
      $display("tb_stereo_multitap_feedback_delay_core passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_stereo_multitap_feedback_delay_core failed");
    end
    $finish;
  end

endmodule
